/* sv/skt_pkg.sv */
// Shared types and constants for the sorted key table.
// Holds the command and status codes, the request and response records,
// the memory port record and the controller state type. No dependencies.
package skt_pkg;

  localparam int DEPTH     = 32;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int POS_W     = 6;
  localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int KEY_W     = 32;
  localparam int PAY_W     = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_FIND   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef struct packed {
    cmd_t             cmd;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    logic [POS_W-1:0] position;
  } req_t;

  typedef struct packed {
    status_t          status;
    logic [KEY_W-1:0] out_key;
    logic [PAY_W-1:0] out_payload;
    logic [POS_W-1:0] entry_count;
    logic             is_full;
    logic             is_empty;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } rec_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    rec_t              wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_EV,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SH_RD,
    S_SH_EV,
    S_RD_EV,
    S_DONE
  } state_t;

  // Count as it appears on the 6-bit entry_count field
  function automatic logic [POS_W-1:0] cnt_to_field(input logic [CNT_W-1:0] c);
    logic [CMP_W-1:0] w;
    w = CMP_W'(c);
    return w[POS_W-1:0];
  endfunction

endpackage

/* sv/skt_mem.sv */
// Record store for the sorted key table: one write port, one read port,
// registered read data. Depends on skt_pkg.
module skt_mem (
  input  logic              clk,
  input  skt_pkg::mem_req_t mem_req,
  output skt_pkg::rec_t     rd_data
);
  import skt_pkg::*;

  rec_t store [DEPTH];

  // Write the addressed entry
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      store[mem_req.waddr] <= mem_req.wdata;
    end
  end

  // Register read data
  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rd_data <= store[mem_req.raddr];
    end
  end

endmodule

/* sv/skt_ctrl.sv */
// Sequencer for the sorted key table: scans the record store one entry at a
// time, shifting entries for insert and remove. Depends on skt_pkg.
module skt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  skt_pkg::req_t     req,
  output skt_pkg::mem_req_t mem_req,
  input  skt_pkg::rec_t     rd_data,
  output logic              done_valid,
  output skt_pkg::rsp_t     done_rsp,
  input  logic              out_ready
);
  import skt_pkg::*;

  state_t             state, state_next;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   idx, idx_next;
  cmd_t               cmd_r, cmd_r_next;
  logic [KEY_W-1:0]   key_r, key_r_next;
  logic [PAY_W-1:0]   pay_r, pay_r_next;
  status_t            res_status, res_status_next;
  logic [KEY_W-1:0]   res_key, res_key_next;
  logic [PAY_W-1:0]   res_pay, res_pay_next;

  logic               accept;
  logic               is_full_now;
  logic               pos_ok;
  logic [CMP_W-1:0]   pos_ext;
  logic [CMP_W-1:0]   pos_m1;
  logic               shift_up;
  logic               key_hit;
  logic [CNT_W-1:0]   idx_p1;

  assign accept      = req_valid && (state == S_IDLE);
  assign is_full_now = (count == CNT_W'(DEPTH));
  assign pos_ext     = CMP_W'(req.position);
  assign pos_m1      = pos_ext - 1'b1;
  assign pos_ok      = (pos_ext != '0) && (pos_ext <= CMP_W'(count));
  assign shift_up    = (rd_data.key >= key_r);
  assign key_hit     = (rd_data.key == key_r);
  assign idx_p1      = idx + 1'b1;

  // Advance the sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (req.cmd)
            CMD_INSERT: state_next = is_full_now ? S_DONE : S_INS_RD;
            CMD_READ:   state_next = pos_ok ? S_RD_EV : S_DONE;
            default:    state_next = S_SCAN_RD;
          endcase
        end
      end
      S_INS_RD:  state_next = (idx == '0) ? S_DONE : S_INS_EV;
      S_INS_EV:  state_next = shift_up ? S_INS_RD : S_DONE;
      S_SCAN_RD: state_next = (idx == count) ? S_DONE : S_SCAN_EV;
      S_SCAN_EV: begin
        if (key_hit) begin
          state_next = (cmd_r == CMD_FIND) ? S_DONE : S_SH_RD;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SH_RD:   state_next = (idx_p1 == count) ? S_DONE : S_SH_EV;
      S_SH_EV:   state_next = S_SH_RD;
      S_RD_EV:   state_next = S_DONE;
      S_DONE:    state_next = out_ready ? S_IDLE : S_DONE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Update count, scan index and result fields
  always_comb begin
    count_next      = count;
    idx_next        = idx;
    cmd_r_next      = cmd_r;
    key_r_next      = key_r;
    pay_r_next      = pay_r;
    res_status_next = res_status;
    res_key_next    = res_key;
    res_pay_next    = res_pay;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_r_next      = req.cmd;
          key_r_next      = req.key;
          pay_r_next      = req.payload;
          res_key_next    = '0;
          res_pay_next    = '0;
          res_status_next = ST_OK;
          idx_next        = '0;
          if (req.cmd == CMD_INSERT) begin
            idx_next = count;
            if (is_full_now) res_status_next = ST_FULL;
          end else if (req.cmd == CMD_READ && !pos_ok) begin
            res_status_next = ST_MISS;
          end
        end
      end
      S_INS_RD: begin
        if (idx == '0) count_next = count + 1'b1;
      end
      S_INS_EV: begin
        if (shift_up) idx_next = idx - 1'b1;
        else          count_next = count + 1'b1;
      end
      S_SCAN_RD: begin
        if (idx == count) res_status_next = ST_MISS;
      end
      S_SCAN_EV: begin
        if (key_hit) begin
          if (cmd_r == CMD_FIND) begin
            res_key_next = rd_data.key;
            res_pay_next = rd_data.payload;
          end
        end else begin
          idx_next = idx_p1;
        end
      end
      S_SH_RD: begin
        if (idx_p1 == count) count_next = count - 1'b1;
      end
      S_SH_EV: idx_next = idx_p1;
      S_RD_EV: begin
        res_key_next = rd_data.key;
        res_pay_next = rd_data.payload;
      end
      default: ;
    endcase
  end

  // Drive memory port and result
  always_comb begin
    mem_req       = '0;
    req_stall     = (state != S_IDLE);
    done_valid    = 1'b0;
    done_rsp.status      = res_status;
    done_rsp.out_key     = res_key;
    done_rsp.out_payload = res_pay;
    done_rsp.entry_count = cnt_to_field(count);
    done_rsp.is_full     = is_full_now;
    done_rsp.is_empty    = (count == '0);
    case (state)
      S_IDLE: begin
        mem_req.re    = accept && (req.cmd == CMD_READ) && pos_ok;
        mem_req.raddr = pos_m1[ADDR_W-1:0];
      end
      S_INS_RD: begin
        if (idx == '0) begin
          mem_req.we            = 1'b1;
          mem_req.waddr         = '0;
          mem_req.wdata.key     = key_r;
          mem_req.wdata.payload = pay_r;
        end else begin
          mem_req.re    = 1'b1;
          mem_req.raddr = ADDR_W'(idx - 1'b1);
        end
      end
      S_INS_EV: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ADDR_W'(idx);
        if (shift_up) begin
          mem_req.wdata = rd_data;
        end else begin
          mem_req.wdata.key     = key_r;
          mem_req.wdata.payload = pay_r;
        end
      end
      S_SCAN_RD: begin
        mem_req.re    = (idx != count);
        mem_req.raddr = ADDR_W'(idx);
      end
      S_SH_RD: begin
        mem_req.re    = (idx_p1 != count);
        mem_req.raddr = ADDR_W'(idx_p1);
      end
      S_SH_EV: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ADDR_W'(idx);
        mem_req.wdata = rd_data;
      end
      S_DONE:  done_valid = 1'b1;
      default: ;
    endcase
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // Hold working registers
  always_ff @(posedge clk) begin
    idx        <= idx_next;
    cmd_r      <= cmd_r_next;
    key_r      <= key_r_next;
    pay_r      <= pay_r_next;
    res_status <= res_status_next;
    res_key    <= res_key_next;
    res_pay    <= res_pay_next;
  end

endmodule

/* sv/skt_out.sv */
// Response register for the sorted key table: holds one finished result
// until the downstream side takes it. Depends on skt_pkg.
module skt_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          done_valid,
  input  skt_pkg::rsp_t done_rsp,
  output logic          out_ready,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output skt_pkg::rsp_t rsp
);
  import skt_pkg::*;

  logic load;

  assign out_ready = !rsp_valid || !rsp_stall;
  assign load      = done_valid && out_ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // Capture payload
  always_ff @(posedge clk) begin
    if (load) begin
      rsp <= done_rsp;
    end
  end

endmodule

/* sv/sorted_key_table.sv */
// Sorted key table: up to DEPTH (32) records of a 32-bit key and 32-bit
// payload, kept in ascending key order in a single-port-write, registered-read
// memory. Each request gives one response. Insert walks down from the top
// entry, moving each larger entry up by one; remove and find walk up from the
// bottom, comparing one entry per step and, for remove, moving later entries
// down; read at position does a single memory read. Every operation ends
// with a response hand-off, and the scan goes one entry per step over the
// memory's single read port. A new request is taken while the previous
// response still waits in the output register.
module sorted_key_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  skt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output skt_pkg::rsp_t rsp
);
  import skt_pkg::*;

  mem_req_t mem_req;
  rec_t     rd_data;
  logic     done_valid;
  rsp_t     done_rsp;
  logic     out_ready;

  skt_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  skt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .mem_req    (mem_req),
    .rd_data    (rd_data),
    .done_valid (done_valid),
    .done_rsp   (done_rsp),
    .out_ready  (out_ready)
  );

  skt_out u_out (
    .clk        (clk),
    .rst        (rst),
    .done_valid (done_valid),
    .done_rsp   (done_rsp),
    .out_ready  (out_ready),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

  // A refused insert only happens on a full table
  a_full_refuse: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == ST_FULL |-> rsp.is_full)
    else $error("full status without full table");

  // Failed commands return no record
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.out_key == '0 && rsp.out_payload == '0)
    else $error("record returned on failed command");

  // The sequencer stays busy the cycle after a request transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken back to back");

  // Memory is never written while a response is being handed off
  a_no_write_in_done: assert property (@(posedge clk) disable iff (rst)
    done_valid |-> !mem_req.we)
    else $error("memory write during response hand-off");

endmodule
